/* rtl/ctw_pkg.sv */
`default_nettype none
package ctw_pkg;

  localparam int FRAC_BITS = 8;
  localparam int IDX_W     = 10;
  localparam int GRID_W    = 11;
  localparam int SPACE_W   = 8;
  localparam int LEN_W     = 18;
  localparam int COORD_W   = 13;
  localparam int XQ_W      = COORD_W + FRAC_BITS - 1;
  localparam int CORDIC_W  = 32;
  localparam int ACC_W     = 18;
  localparam int PHI_W     = 17;
  localparam int STEPS     = 15;
  localparam int TURN      = 65536;
  localparam int HALF_TURN = 32768;
  localparam int SLANT_W   = 44;
  localparam int HELIX_W   = 48;
  localparam int WALL_THICK = 5 << FRAC_BITS;

  typedef enum logic [2:0] {
    REG_MODE         = 3'd0,
    REG_GRID_WIDTH   = 3'd1,
    REG_GRID_DEPTH   = 3'd2,
    REG_SPACE_CELLS  = 3'd3,
    REG_RADIUS_CELLS = 3'd4,
    REG_CUT_LENGTH   = 3'd5,
    REG_FEED_LENGTH  = 3'd6
  } ctw_reg_t;

  localparam logic [1:0] MODE_SLANT  = 2'd0;
  localparam logic [1:0] MODE_MIRROR = 2'd1;
  localparam logic [1:0] MODE_DIRECT = 2'd2;
  // unused code, behaves as the direct angle mode
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [GRID_W-1:0]  grid_width;
    logic [GRID_W-1:0]  grid_depth;
    logic [SPACE_W-1:0] space_cells;
    logic [LEN_W-1:0]   radius_cells;
    logic [LEN_W-1:0]   cut_length;
    logic [LEN_W-1:0]   feed_length;
  } ctw_cfg_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] u;
    logic signed [CORDIC_W-1:0] v;
    logic signed [ACC_W-1:0]    acc;
    logic signed [XQ_W-1:0]     zq;
    logic                       ring_ok;
    logic                       cut_ok;
  } ctw_item_t;

  function automatic logic signed [ACC_W-1:0] turn_step(input int s);
    case (s)
      0:  return 18'sd8192;
      1:  return 18'sd4836;
      2:  return 18'sd2555;
      3:  return 18'sd1297;
      4:  return 18'sd651;
      5:  return 18'sd326;
      6:  return 18'sd163;
      7:  return 18'sd81;
      8:  return 18'sd41;
      9:  return 18'sd20;
      10: return 18'sd10;
      11: return 18'sd5;
      12: return 18'sd3;
      default: return 18'sd1;
    endcase
  endfunction

endpackage
`default_nettype wire

/* rtl/ctw_if.sv */
`default_nettype none
interface ctw_voxel_if;
  import ctw_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] col_index;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] layer_index;
  modport source (output valid, col_index, row_index, layer_index, input ready);
  modport sink (input valid, col_index, row_index, layer_index, output ready);
endinterface

interface ctw_result_if;
  logic valid;
  logic ready;
  logic is_wall;
  modport source (output valid, is_wall, input ready);
  modport sink (input valid, is_wall, output ready);
endinterface
`default_nettype wire

/* rtl/ctw_cordic_cell.sv */
`default_nettype none
module ctw_cordic_cell
  import ctw_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire logic      in_valid,
  input  wire ctw_item_t in_item,
  output logic           out_valid,
  output ctw_item_t      out_item
);

  ctw_item_t item_next;
  logic signed [CORDIC_W-1:0] du;
  logic signed [CORDIC_W-1:0] dv;

  // one vectoring rotation, shifts floor toward minus infinity
  always_comb begin
    du = in_item.v >>> STEP;
    dv = in_item.u >>> STEP;
    item_next = in_item;
    if (!in_item.v[CORDIC_W-1]) begin
      item_next.u   = in_item.u + du;
      item_next.v   = in_item.v - dv;
      item_next.acc = in_item.acc + turn_step(STEP);
    end else begin
      item_next.u   = in_item.u - du;
      item_next.v   = in_item.v + dv;
      item_next.acc = in_item.acc - turn_step(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/ctw_front.sv */
`default_nettype none
module ctw_front
  import ctw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire ctw_cfg_t         cfg,
  input  wire logic             in_valid,
  input  wire logic [IDX_W-1:0] col_index,
  input  wire logic [IDX_W-1:0] row_index,
  input  wire logic [IDX_W-1:0] layer_index,
  output logic                  out_valid,
  output ctw_item_t             out_item
);

  // stage 0: centre coordinates and cordic start vector
  logic signed [COORD_W-1:0]  x2_next, y2_next, z2_next;
  logic signed [CORDIC_W-1:0] u_next, v_next;
  logic signed [ACC_W-1:0]    acc_next;

  logic                       s0_valid;
  logic signed [XQ_W-1:0]     xq, yq, zq;
  logic signed [CORDIC_W-1:0] u0, v0;
  logic signed [ACC_W-1:0]    acc0;

  always_comb begin
    x2_next = $signed({2'b0, col_index, 1'b0}) - $signed({2'b0, cfg.grid_width})
              + 13'sd1;
    y2_next = $signed({2'b0, row_index, 1'b0}) - $signed({2'b0, cfg.grid_depth})
              + 13'sd1;
    z2_next = $signed({2'b0, layer_index, 1'b1}) - $signed({4'b0, cfg.space_cells, 1'b0});
    u_next  = CORDIC_W'($signed({y2_next, 16'b0}));
    v_next  = CORDIC_W'($signed({x2_next, 16'b0}));
    acc_next = '0;
    if (y2_next < 0) begin
      acc_next = (x2_next >= 0) ? ACC_W'(HALF_TURN) : -ACC_W'(HALF_TURN);
      u_next   = -u_next;
      v_next   = -v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xq   <= $signed({x2_next, {(FRAC_BITS-1){1'b0}}});
      yq   <= $signed({y2_next, {(FRAC_BITS-1){1'b0}}});
      zq   <= $signed({z2_next, {(FRAC_BITS-1){1'b0}}});
      u0   <= u_next;
      v0   <= v_next;
      acc0 <= acc_next;
    end
  end

  // stage 1: products and height compares
  logic                        s1_valid;
  logic signed [2*XQ_W-1:0]    xx, yy;
  logic [2*LEN_W+1:0]          rr, oo;
  logic signed [SLANT_W-1:0]   p_rz, p_xl, p_rl, p_rc;
  logic                        z_below, z_above;
  ctw_item_t                   s1_item;
  logic [LEN_W:0]              outer;

  assign outer = {1'b0, cfg.radius_cells} + (LEN_W+1)'(WALL_THICK);

  always_ff @(posedge clk) begin
    if (en) begin
      xx   <= (2*XQ_W)'(xq) * (2*XQ_W)'(xq);
      yy   <= (2*XQ_W)'(yq) * (2*XQ_W)'(yq);
      rr   <= (2*LEN_W+2)'(cfg.radius_cells) * (2*LEN_W+2)'(cfg.radius_cells);
      oo   <= (2*LEN_W+2)'(outer) * (2*LEN_W+2)'(outer);
      p_rz <= SLANT_W'($signed({1'b0, cfg.radius_cells, 1'b0})) * SLANT_W'(zq);
      p_xl <= SLANT_W'(xq) * SLANT_W'($signed({1'b0, cfg.cut_length}));
      p_rl <= $signed(SLANT_W'({cfg.radius_cells, 1'b0} * SLANT_W'(cfg.feed_length)));
      p_rc <= $signed(SLANT_W'(cfg.radius_cells) * SLANT_W'(cfg.cut_length));
      z_below <= zq < $signed({2'b0, {1'b0, cfg.cut_length} + {1'b0, cfg.feed_length}});
      z_above <= zq > $signed({2'b0, cfg.feed_length});
      s1_item.u       <= u0;
      s1_item.v       <= v0;
      s1_item.acc     <= acc0;
      s1_item.zq      <= zq;
      s1_item.ring_ok <= 1'b0;
      s1_item.cut_ok  <= 1'b0;
    end
  end

  // stage 2: ring and slant compares
  logic signed [2*XQ_W+1:0] rad2;
  logic                     slant_clear;
  ctw_item_t                item2_next;

  always_comb begin
    rad2 = (2*XQ_W+2)'(xx) + (2*XQ_W+2)'(yy);
    slant_clear = z_above && (p_rz > p_xl + p_rl + p_rc);
    item2_next = s1_item;
    item2_next.ring_ok = (rad2 > $signed((2*XQ_W+2)'(rr)))
                      && (rad2 < $signed((2*XQ_W+2)'(oo)));
    item2_next.cut_ok  = (cfg.mode == MODE_SLANT) ? (z_below && !slant_clear) : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s0_valid  <= in_valid;
      s1_valid  <= s0_valid;
      out_valid <= s1_valid;
    end
  end

endmodule
`default_nettype wire

/* rtl/cut_tube_wall_voxel_classifier.sv */
//  channel  | direction | fields                              | handshake
//  voxel    | in        | col_index, row_index, layer_index   | valid/ready
//  result   | out       | is_wall                             | valid/ready
//  apb      | in/out    | mode .. feed_length at 4*index      | psel/penable
//
//  one request per cycle while the result slot is free or drains; 3 front stages,
//  15 cordic cells and 2 final stages lie between voxel and result
//  rst is synchronous and clears every stage valid; config goes to reset values
//  the whole chain moves together: when the result register is full and not
//  taken, every stage holds and voxel.ready drops
`default_nettype none
module cut_tube_wall_voxel_classifier
  import ctw_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  ctw_voxel_if.sink         voxel,
  ctw_result_if.source      result,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  ctw_cfg_t cfg;
  ctw_reg_t reg_sel;
  logic     advance;

  assign pready  = 1'b1;
  assign reg_sel = ctw_reg_t'(paddr[4:2]);

  // configuration registers, written on the apb access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_SLANT;
      cfg.grid_width   <= GRID_W'(64);
      cfg.grid_depth   <= GRID_W'(64);
      cfg.space_cells  <= SPACE_W'(10);
      cfg.radius_cells <= LEN_W'(5120);
      cfg.cut_length   <= LEN_W'(10240);
      cfg.feed_length  <= LEN_W'(5120);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_MODE:         cfg.mode         <= pwdata[1:0];
        REG_GRID_WIDTH:   cfg.grid_width   <= pwdata[GRID_W-1:0];
        REG_GRID_DEPTH:   cfg.grid_depth   <= pwdata[GRID_W-1:0];
        REG_SPACE_CELLS:  cfg.space_cells  <= pwdata[SPACE_W-1:0];
        REG_RADIUS_CELLS: cfg.radius_cells <= pwdata[LEN_W-1:0];
        REG_CUT_LENGTH:   cfg.cut_length   <= pwdata[LEN_W-1:0];
        REG_FEED_LENGTH:  cfg.feed_length  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      REG_MODE:         prdata = 32'(cfg.mode);
      REG_GRID_WIDTH:   prdata = 32'(cfg.grid_width);
      REG_GRID_DEPTH:   prdata = 32'(cfg.grid_depth);
      REG_SPACE_CELLS:  prdata = 32'(cfg.space_cells);
      REG_RADIUS_CELLS: prdata = 32'(cfg.radius_cells);
      REG_CUT_LENGTH:   prdata = 32'(cfg.cut_length);
      REG_FEED_LENGTH:  prdata = 32'(cfg.feed_length);
      default:          prdata = '0;
    endcase
  end

  // global pipeline advance: move whenever the result slot is free or drains
  assign advance     = !result.valid || result.ready;
  assign voxel.ready = advance;

  // front: coordinates, ring and slant tests, cordic start vector
  logic      chain_valid [0:STEPS];
  ctw_item_t chain_item  [0:STEPS];

  ctw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .cfg         (cfg),
    .in_valid    (voxel.valid),
    .col_index   (voxel.col_index),
    .row_index   (voxel.row_index),
    .layer_index (voxel.layer_index),
    .out_valid   (chain_valid[0]),
    .out_item    (chain_item[0])
  );

  // row of cordic cells, one rotation each, data handed on every cycle the chain advances
  for (genvar s = 0; s < STEPS; s++) begin : g_cell
    ctw_cordic_cell #(
      .STEP (s)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (chain_valid[s]),
      .in_item   (chain_item[s]),
      .out_valid (chain_valid[s+1]),
      .out_item  (chain_item[s+1])
    );
  end

  // final stage 1: angle from accumulator, clamp, mirror, cut length product
  ctw_item_t               last;
  logic signed [ACC_W:0]   phi_raw;
  logic [PHI_W-1:0]        phi;
  logic                    f1_valid;
  logic signed [XQ_W-1:0]  f1_zq;
  logic                    f1_ring;
  logic                    f1_cut;
  logic [LEN_W+PHI_W-1:0]  f1_prod;

  assign last = chain_item[STEPS];

  always_comb begin
    phi_raw = (ACC_W+1)'(last.acc) + (ACC_W+1)'(HALF_TURN);
    if (phi_raw < 0) begin
      phi = '0;
    end else if (phi_raw > (ACC_W+1)'(TURN)) begin
      phi = PHI_W'(TURN);
    end else begin
      phi = phi_raw[PHI_W-1:0];
    end
    if (cfg.mode == MODE_MIRROR) begin
      phi = PHI_W'(TURN) - phi;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f1_zq   <= last.zq;
      f1_ring <= last.ring_ok;
      f1_cut  <= last.cut_ok;
      f1_prod <= (LEN_W+PHI_W)'(cfg.cut_length) * (LEN_W+PHI_W)'(phi);
    end
  end

  // final stage 2: helical height compare, result register
  logic signed [HELIX_W-1:0] z_lhs, z_rhs;
  logic                      helix_ok;

  always_comb begin
    z_lhs    = HELIX_W'($signed({f1_zq, 16'b0}));
    z_rhs    = $signed(HELIX_W'({cfg.feed_length, 16'b0}) + HELIX_W'(f1_prod));
    helix_ok = z_lhs < z_rhs;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.is_wall <= f1_ring && f1_cut && ((cfg.mode == MODE_SLANT) || helix_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else if (advance) begin
      f1_valid     <= chain_valid[STEPS];
      result.valid <= f1_valid;
    end
  end

endmodule
`default_nettype wire

/* test/cut_tube_wall_voxel_classifier_tb.sv */
module cut_tube_wall_voxel_classifier_tb;
  import ctw_pkg::*;

  // voxel index triple as offered on the input channel
  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] layer;
  } voxel_req_t;

  localparam int LATENCY    = 20;
  localparam int LIMIT      = 400000;
  // marker in the request queue: sender waits until every expected result is in
  localparam int DRAIN_FLAG = 1;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ctw_voxel_if voxel ();
  ctw_result_if result ();

  cut_tube_wall_voxel_classifier uut (
    .clk(clk), .rst(rst), .voxel(voxel.sink), .result(result.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // testbench copy of the block registers
  ctw_cfg_t cfg;

  voxel_req_t voxel_queue[$];
  bit         pause_queue[$];
  bit         wall_expected[$];
  int  errors = 0;
  int  cycles = 0;
  bit  in_taken = 0;
  bit  tx_gap_on = 1, rx_gap_on = 1;
  int  rx_hold = 0;
  int  tx_gap = 0, rx_gap = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // short gaps mostly, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // arithmetic shift right rounding toward minus infinity
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint turn_entry(int s);
    case (s)
      0: return 8192;   1: return 4836;  2: return 2555;  3: return 1297;
      4: return 651;    5: return 326;   6: return 163;   7: return 81;
      8: return 41;     9: return 20;    10: return 10;   11: return 5;
      12: return 3;     default: return 1;
    endcase
  endfunction

  // angle atan2(x, y) + half turn in Q0.16 turns via vectoring rotations
  function automatic longint helix_angle(longint x2, longint y2);
    longint u, v, acc, du, dv, phi;
    u = y2 * 65536;
    v = x2 * 65536;
    acc = 0;
    if (u < 0) begin
      acc = (v >= 0) ? HALF_TURN : -HALF_TURN;
      u = -u;
      v = -v;
    end
    for (int s = 0; s < STEPS; s++) begin
      du = floor_shift(v, s);
      dv = floor_shift(u, s);
      if (v >= 0) begin
        u += du; v -= dv; acc += turn_entry(s);
      end else begin
        u -= du; v += dv; acc -= turn_entry(s);
      end
    end
    phi = acc + HALF_TURN;
    if (phi < 0) phi = 0;
    if (phi > TURN) phi = TURN;
    return phi;
  endfunction

  function automatic bit classify_voxel(voxel_req_t q);
    longint half, x2, y2, z2, xq, yq, zq, r, lc, lp, outer, r2, phi;
    bit wall;
    half = 1 << (FRAC_BITS - 1);
    x2 = 2 * longint'(q.col) - longint'(cfg.grid_width) + 1;
    y2 = 2 * longint'(q.row) - longint'(cfg.grid_depth) + 1;
    z2 = 2 * longint'(q.layer) + 1 - 2 * longint'(cfg.space_cells);
    xq = x2 * half;
    yq = y2 * half;
    zq = z2 * half;
    r = cfg.radius_cells;
    lc = cfg.cut_length;
    lp = cfg.feed_length;
    outer = r + WALL_THICK;
    r2 = xq * xq + yq * yq;
    wall = (r2 > r * r) && (r2 < outer * outer);
    if (cfg.mode == MODE_SLANT) begin
      if (!(zq < lc + lp)) wall = 0;
      if (zq > lp && 2 * r * zq > xq * lc + 2 * r * lp + r * lc) wall = 0;
    end else begin
      phi = helix_angle(x2, y2);
      if (cfg.mode == MODE_MIRROR) phi = TURN - phi;
      if (!(zq * TURN < lp * TURN + lc * phi)) wall = 0;
    end
    return wall;
  endfunction

  // driver: offers queued requests, predicts each one once it was accepted
  always @(negedge clk) begin : drive
    int gap;
    gap = tx_gap;
    if (!rst) begin
      if (in_taken) begin
        wall_expected.push_back(classify_voxel(voxel_queue.pop_front()));
        void'(pause_queue.pop_front());
        gap = tx_gap_on ? pick_gap() : 0;
      end
      if (voxel.valid && !in_taken) begin
        // keep offering the same request
      end else if (gap > 0) begin
        gap = gap - 1;
        voxel.valid <= 0;
      end else if (voxel_queue.size() > 0 &&
                   !(pause_queue[0] == DRAIN_FLAG && wall_expected.size() > 0)) begin
        voxel.valid <= 1;
        voxel.col_index <= voxel_queue[0].col;
        voxel.row_index <= voxel_queue[0].row;
        voxel.layer_index <= voxel_queue[0].layer;
      end else begin
        voxel.valid <= 0;
      end
      tx_gap <= gap;
    end
  end

  // receiver stall generator
  always @(negedge clk) begin
    if (!rst) begin
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        result.ready <= 0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        result.ready <= 0;
      end else begin
        result.ready <= 1;
        rx_gap <= rx_gap_on ? pick_gap() : 0;
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken <= !rst && voxel.valid && voxel.ready;
    if (!rst && result.valid && result.ready) begin
      if (wall_expected.size() == 0) begin
        $error("is_wall: unexpected result, actual %0b", result.is_wall);
        errors++;
      end else begin
        bit exp_wall;
        exp_wall = wall_expected.pop_front();
        if (result.is_wall !== exp_wall) begin
          $error("is_wall: expected %0b actual %0b", exp_wall, result.is_wall);
          errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic apb_write(ctw_reg_t idx, logic [31:0] data);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 5'(idx) << 2; pwdata <= data;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_MODE:         cfg.mode = data[1:0];
      REG_GRID_WIDTH:   cfg.grid_width = data[GRID_W-1:0];
      REG_GRID_DEPTH:   cfg.grid_depth = data[GRID_W-1:0];
      REG_SPACE_CELLS:  cfg.space_cells = data[SPACE_W-1:0];
      REG_RADIUS_CELLS: cfg.radius_cells = data[LEN_W-1:0];
      REG_CUT_LENGTH:   cfg.cut_length = data[LEN_W-1:0];
      default:          cfg.feed_length = data[LEN_W-1:0];
    endcase
  endtask

  task automatic queue_voxel(int c, int r, int l, bit drain_first = 0);
    voxel_req_t q;
    q.col = c; q.row = r; q.layer = l;
    voxel_queue.push_back(q);
    pause_queue.push_back(drain_first);
  endtask

  // idle point between phases: everything sent, every result in, pipe flushed
  task automatic wait_idle();
    while (voxel_queue.size() > 0 || wall_expected.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // random voxel inside the grid area most of the time, anywhere otherwise
  task automatic queue_random(int n);
    int c, r, l;
    for (int t = 0; t < n; t++) begin
      if ($urandom_range(0, 3) != 0 && cfg.grid_width <= 1024) begin
        c = $urandom_range(0, cfg.grid_width > 0 ? cfg.grid_width - 1 : 0);
        r = $urandom_range(0, cfg.grid_depth > 0 ? cfg.grid_depth - 1 : 0);
        l = $urandom_range(0, 80);
      end else begin
        c = $urandom_range(0, 1023);
        r = $urandom_range(0, 1023);
        l = $urandom_range(0, 1023);
      end
      queue_voxel(c, r, l);
    end
  endtask

  initial begin
    voxel.valid = 0;
    voxel.col_index = '0;
    voxel.row_index = '0;
    voxel.layer_index = '0;
    result.ready = 0;
    cfg = '{mode: 0, grid_width: 64, grid_depth: 64, space_cells: 10,
            radius_cells: 5120, cut_length: 10240, feed_length: 5120};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: field extremes, axis centre, outside grid, all modes
    queue_voxel(0, 0, 0);
    queue_voxel(1023, 1023, 1023);
    queue_voxel(32, 32, 10);
    queue_voxel(32, 9, 12);
    queue_voxel(32, 56, 40);
    queue_voxel(5, 32, 30);
    queue_voxel(58, 32, 60);
    queue_voxel(682, 341, 682);
    wait_idle();
    apb_write(REG_MODE, 32'(MODE_MIRROR));
    queue_voxel(32, 9, 20); queue_voxel(9, 32, 20); queue_voxel(56, 32, 50);
    queue_voxel(32, 56, 50); queue_voxel(0, 1023, 5);
    wait_idle();
    apb_write(REG_MODE, 32'(MODE_DIRECT));
    queue_voxel(32, 9, 20); queue_voxel(9, 32, 20); queue_voxel(56, 32, 50);
    queue_voxel(32, 56, 50);
    wait_idle();
    apb_write(REG_MODE, 32'(MODE_SPARE));    // unused code acts as direct angle
    queue_voxel(9, 32, 20); queue_voxel(56, 32, 50);
    wait_idle();

    // zero radius and zero grid in slant mode
    apb_write(REG_MODE, 32'(MODE_SLANT));
    apb_write(REG_RADIUS_CELLS, 32'd0);
    apb_write(REG_GRID_WIDTH, 32'd0);
    apb_write(REG_GRID_DEPTH, 32'd0);
    queue_voxel(0, 0, 0); queue_voxel(2, 1, 5); queue_voxel(1023, 0, 3);
    queue_voxel(1, 2, 20, 1);
    wait_idle();

    // phases over several settings, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          apb_write(REG_MODE, 32'(MODE_SLANT));
          apb_write(REG_GRID_WIDTH, 32'd64); apb_write(REG_GRID_DEPTH, 32'd64);
          apb_write(REG_SPACE_CELLS, 32'd10);
          apb_write(REG_RADIUS_CELLS, 32'd5120);
          apb_write(REG_CUT_LENGTH, 32'd10240);
          apb_write(REG_FEED_LENGTH, 32'd5120);
        end
        1: begin
          apb_write(REG_MODE, 32'(MODE_MIRROR));
          apb_write(REG_GRID_WIDTH, 32'd40); apb_write(REG_GRID_DEPTH, 32'd33);
          apb_write(REG_SPACE_CELLS, 32'd0);
          apb_write(REG_RADIUS_CELLS, 32'd3000);
          apb_write(REG_CUT_LENGTH, 32'd8000);
          apb_write(REG_FEED_LENGTH, 32'd2000);
        end
        2: begin
          apb_write(REG_MODE, 32'(MODE_DIRECT));
          apb_write(REG_SPACE_CELLS, 32'd255);
          apb_write(REG_CUT_LENGTH, 32'h3FFFF);
          apb_write(REG_FEED_LENGTH, 32'd0);
        end
        3: begin
          apb_write(REG_MODE, 32'(MODE_SLANT));
          apb_write(REG_GRID_WIDTH, 32'd1024); apb_write(REG_GRID_DEPTH, 32'd1024);
          apb_write(REG_SPACE_CELLS, 32'd0);
          apb_write(REG_RADIUS_CELLS, 32'h3FFFF);
          apb_write(REG_CUT_LENGTH, 32'h3FFFF);
          apb_write(REG_FEED_LENGTH, 32'h3FFFF);
        end
        4: begin
          apb_write(REG_GRID_WIDTH, 32'd1); apb_write(REG_GRID_DEPTH, 32'd1);
          apb_write(REG_RADIUS_CELLS, 32'd0);
          apb_write(REG_CUT_LENGTH, 32'd0);
          apb_write(REG_FEED_LENGTH, 32'd700);
        end
        default: begin
          apb_write(REG_MODE, 32'(MODE_MIRROR));
          apb_write(REG_GRID_WIDTH, 32'h7FF); apb_write(REG_GRID_DEPTH, 32'd20);
          apb_write(REG_RADIUS_CELLS, 32'd1500);
          apb_write(REG_CUT_LENGTH, 32'd6000);
          apb_write(REG_FEED_LENGTH, 32'd1000);
        end
      endcase
      // one phase without gaps, one with a long receiver hold-off
      tx_gap_on = (ph != 2);
      rx_gap_on = (ph != 2);
      if (ph == 1) rx_hold = 200;
      queue_random(ph == 3 ? 40 : 70);
      if (ph == 0) queue_voxel(32, 9, 12, DRAIN_FLAG);
      wait_idle();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ctw_pkg.sv
rtl/ctw_if.sv
rtl/ctw_cordic_cell.sv
rtl/ctw_front.sv
rtl/cut_tube_wall_voxel_classifier.sv
test/cut_tube_wall_voxel_classifier_tb.sv
